// ===== design/wma_pkg.sv =====
// shared constants, types and helpers for the windowed moving average block
package wma_pkg;

	localparam int MAX_WINDOW = 32;
	localparam int AW         = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW         = $clog2(MAX_WINDOW + 1);
	localparam int DATA_W     = 32;
	localparam int TIME_W     = 16;
	localparam int ELAPSED_W  = 32;
	localparam int WL_W       = 6;
	localparam int LIMIT_W    = 14;
	localparam int CFG_W      = 14;
	localparam int SUM_W      = DATA_W + AW;
	localparam int DIV_CNT_W  = $clog2(SUM_W);

	localparam logic [LIMIT_W-1:0] COUNT_MAX = '1;

	typedef enum logic {
		REG_WINDOW = 1'b0,
		REG_LIMIT  = 1'b1
	} reg_idx_t;

	typedef enum logic {
		REQ_START  = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UPD,
		S_DIV,
		S_DONE
	} state_t;

	// window size in use: zero acts as one, large values clamp to capacity
	function automatic logic [CW-1:0] eff_window(input logic [WL_W-1:0] wl);
		logic [CW-1:0] w;
		w = CW'(1);
		if (wl == '0) begin
			w = CW'(1);
		end else if (int'(wl) > MAX_WINDOW) begin
			w = CW'(MAX_WINDOW);
		end else begin
			w = CW'(wl);
		end
		return w;
	endfunction

endpackage

// ===== design/wma_ram.sv =====
// generic single-write, single-read ram with registered read data
module wma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/windowed_moving_average.sv =====
// windowed moving average: sample ring in ram, running sum, iterative divider
// a sample passes from accept through the update, divide and done states to a result;
// the divide is bit-serial restoring, one quotient bit per cycle
// a start item gives no result and leaves the block idle; the next item is taken while
// a result waits in the output register
// arst_n clears control state and counters; the ring is not cleared, no sweep
module windowed_moving_average
	import wma_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic signed [DATA_W-1:0]    sample_value,
	input  logic [TIME_W-1:0]           time_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [DATA_W-1:0]    average,
	output logic [ELAPSED_W-1:0]        elapsed_ms,
	output logic                        last_of_run,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data
);

	state_t state_q, state_d;

	logic [WL_W-1:0]          window_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [AW-1:0]            write_slot_q;
	logic [CW-1:0]            fill_q;
	logic [LIMIT_W-1:0]       taken_q;
	logic [TIME_W-1:0]        prev_time_q;
	logic [ELAPSED_W-1:0]     elapsed_q;
	logic                     run_active_q;

	logic [DATA_W-1:0]        raw_q;
	logic [TIME_W-1:0]        time_q;
	logic [AW-1:0]            slot_q;
	logic                     drop_q;

	logic [SUM_W-1:0]         quo_q;
	logic [CW-1:0]            rem_q;
	logic [CW-1:0]            div_q;
	logic                     neg_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic                     last_q;

	logic                     out_valid_q;
	logic [DATA_W-1:0]        average_q;
	logic [ELAPSED_W-1:0]     elapsed_out_q;
	logic                     last_out_q;

	logic [CW-1:0]            win_c;
	logic [AW-1:0]            slot_c;
	logic                     in_acc;
	logic                     out_acc;
	logic                     out_load;
	logic [DATA_W-1:0]        ram_rdata;
	logic signed [SUM_W-1:0]  sum_next;
	logic [SUM_W-1:0]         sum_abs;
	logic [CW-1:0]            fill_next;
	logic [AW:0]              slot_inc;
	logic [TIME_W-1:0]        dt;
	logic [LIMIT_W-1:0]       taken_next;
	logic                     last_c;
	logic [CW:0]              rem_ext;
	logic                     q_bit;
	logic [CW-1:0]            rem_next;
	logic [SUM_W-1:0]         avg_full;

	assign win_c    = eff_window(window_q);
	assign slot_c   = (write_slot_q >= win_c) ? '0 : write_slot_q;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	wma_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (state_q == S_UPD),
		.waddr(slot_q),
		.wdata(raw_q),
		.raddr(slot_c),
		.rdata(ram_rdata)
	);

	// sum update: add the new sample, drop the oldest once the ring is full
	always_comb begin
		sum_next = sum_q + {{(SUM_W-DATA_W){raw_q[DATA_W-1]}}, raw_q};
		if (drop_q) begin
			sum_next = sum_next - {{(SUM_W-DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};
		end
		sum_abs    = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
		fill_next  = drop_q ? win_c : fill_q + CW'(1);
		slot_inc   = {1'b0, slot_q} + (AW+1)'(1);
		dt         = time_q - prev_time_q;
		taken_next = (taken_q != COUNT_MAX) ? taken_q + LIMIT_W'(1) : taken_q;
		last_c     = (limit_q != '0) && (taken_next >= limit_q);
	end

	// one restoring step on the magnitude
	always_comb begin
		rem_ext  = {rem_q, quo_q[SUM_W-1]};
		q_bit    = (rem_ext >= {1'b0, div_q});
		rem_next = q_bit ? CW'(rem_ext - {1'b0, div_q}) : rem_ext[CW-1:0];
		avg_full = neg_q ? SUM_W'(-quo_q) : quo_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && req_type == REQ_SAMPLE && run_active_q) begin
					state_d = S_UPD;
				end
			end
			S_UPD:  state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == '0) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WL_W'(1);
			limit_q      <= '0;
			sum_q        <= '0;
			write_slot_q <= '0;
			fill_q       <= '0;
			taken_q      <= '0;
			prev_time_q  <= '0;
			elapsed_q    <= '0;
			run_active_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_acc && req_type == REQ_START) begin
				sum_q        <= '0;
				write_slot_q <= '0;
				fill_q       <= '0;
				taken_q      <= '0;
				elapsed_q    <= '0;
				prev_time_q  <= time_ms;
				run_active_q <= 1'b1;
			end
			if (state_q == S_UPD) begin
				sum_q        <= sum_next;
				fill_q       <= fill_next;
				write_slot_q <= (slot_inc >= win_c) ? '0 : slot_inc[AW-1:0];
				elapsed_q    <= elapsed_q + ELAPSED_W'(dt);
				prev_time_q  <= time_q;
				taken_q      <= taken_next;
				if (last_c) begin
					run_active_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_WINDOW: begin
						window_q     <= cfg_data[WL_W-1:0];
						run_active_q <= 1'b0;
					end
					REG_LIMIT:  limit_q <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item capture, divider and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q  <= sample_value;
			time_q <= time_ms;
			slot_q <= slot_c;
			drop_q <= (fill_q >= win_c);
		end
		if (state_q == S_UPD) begin
			quo_q  <= sum_abs;
			rem_q  <= '0;
			div_q  <= fill_next;
			neg_q  <= sum_next[SUM_W-1];
			cnt_q  <= DIV_CNT_W'(SUM_W - 1);
			last_q <= last_c;
		end else if (state_q == S_DIV) begin
			quo_q <= {quo_q[SUM_W-2:0], q_bit};
			rem_q <= rem_next;
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
		if (out_load) begin
			average_q     <= avg_full[DATA_W-1:0];
			elapsed_out_q <= elapsed_q;
			last_out_q    <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign average     = average_q;
	assign elapsed_ms  = elapsed_out_q;
	assign last_of_run = last_out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= MAX_WINDOW)
		else $error("fill count above capacity");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(write_slot_q) < MAX_WINDOW)
		else $error("write slot out of range");

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req_type == REQ_SAMPLE && run_active_q |=> state_q == S_UPD)
		else $error("accepted sample did not start an update");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_q != '0)
		else $error("divide by zero fill count");

	a_done_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_DONE) |-> $past(state_q) == S_DIV && $past(cnt_q) == '0)
		else $error("result stage entered before divide finished");

endmodule
